FILE: rtl/lvn_pkg.sv
// ----------------------------------------------------------------------------
// lvn_pkg
// shared constants and types for the l2 vector normalizer
// ----------------------------------------------------------------------------
package lvn_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int DEPTH     = 64;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  // each square is below 2^(2*(SAMPLE_W-1)) + 1, summed over DEPTH entries
  localparam int SUM_W     = 2 * (SAMPLE_W - 1) + $clog2(DEPTH) + 1;
  localparam int ROOT_W    = (SUM_W + 1) / 2;
  localparam int FRAC_OUT  = 14;
  localparam int QUOT_W    = FRAC_OUT + 1;
  localparam int OUT_W     = 16;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } lvn_stat_t;

endpackage

FILE: rtl/lvn_sqrt.sv
// ----------------------------------------------------------------------------
// lvn_sqrt
// digit-serial integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module lvn_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lvn_pkg::SUM_W-1:0]     radicand,
  output logic [lvn_pkg::ROOT_W-1:0]    root,
  output lvn_pkg::lvn_stat_t            stat
);
  import lvn_pkg::*;

  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_r,  rad_nxt;
  logic [REM_W-1:0]  rem_r,  rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [STEP_W-1:0] cnt_r,  cnt_nxt;
  logic              done_r, done_nxt;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  always_comb begin
    rem_sh   = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial    = REM_W'({root_r, 2'b01});
    ge       = (rem_sh >= trial);
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = RAD_W'(radicand);
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = STEP_W'(ROOT_W);
    end else if (cnt_r != '0) begin
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[ROOT_W-2:0], ge};
      cnt_nxt  = cnt_r - STEP_W'(1);
      done_nxt = (cnt_r == STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root      = root_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

FILE: rtl/lvn_div.sv
// ----------------------------------------------------------------------------
// lvn_div
// bit-serial restoring divider, magnitude * 2^FRAC_OUT over the norm
// ----------------------------------------------------------------------------
module lvn_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lvn_pkg::SAMPLE_W-1:0]  mag,
  input  logic [lvn_pkg::ROOT_W-1:0]    divisor,
  output logic [lvn_pkg::QUOT_W-1:0]    quot,
  output lvn_pkg::lvn_stat_t            stat
);
  import lvn_pkg::*;

  localparam int REM_W  = ROOT_W + 1;
  localparam int STEP_W = $clog2(QUOT_W + 1);

  logic [REM_W-1:0]  rem_r,   rem_nxt;
  logic [QUOT_W-1:0] quot_r,  quot_nxt;
  logic [STEP_W-1:0] cnt_r,   cnt_nxt;
  logic              first_r, first_nxt;
  logic              done_r,  done_nxt;

  logic [REM_W-1:0]  cur;
  logic [REM_W-1:0]  dvs;
  logic              ge;

  // the magnitude never exceeds the norm, so the top quotient bit
  // is taken before any shift
  always_comb begin
    cur       = first_r ? rem_r : {rem_r[REM_W-2:0], 1'b0};
    dvs       = REM_W'(divisor);
    ge        = (cur >= dvs);
    rem_nxt   = rem_r;
    quot_nxt  = quot_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    done_nxt  = 1'b0;
    if (start) begin
      rem_nxt   = REM_W'(mag);
      quot_nxt  = '0;
      cnt_nxt   = STEP_W'(QUOT_W);
      first_nxt = 1'b1;
    end else if (cnt_r != '0) begin
      rem_nxt   = ge ? (cur - dvs) : cur;
      quot_nxt  = {quot_r[QUOT_W-2:0], ge};
      cnt_nxt   = cnt_r - STEP_W'(1);
      first_nxt = 1'b0;
      done_nxt  = (cnt_r == STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r   <= rem_nxt;
    quot_r  <= quot_nxt;
    first_r <= first_nxt;
  end

  assign quot      = quot_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

FILE: rtl/l2_vector_normalize.sv
// ----------------------------------------------------------------------------
// l2_vector_normalize
// sequence: a stored element is accepted, then squared by shift-add one magnitude
//   bit per step up to its highest one, and a last step closes the square;
//   a dropped element is only accepted. After the final element the square root
//   runs, then the bit-serial divider gives the results one by one
// reset: synchronous active-low rst_n empties the store and clears the sum
// ----------------------------------------------------------------------------
module l2_vector_normalize (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [lvn_pkg::SAMPLE_W-1:0]  in_element,
  input  logic                                 in_is_final,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lvn_pkg::OUT_W-1:0]     out_unit_value,
  output logic                                 out_end_of_vector
);
  import lvn_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD,       // waiting for an element transfer
    ST_SQUARE,     // shift-add squaring into the running sum
    ST_ROOT_GO,    // kick off the square root
    ST_ROOT_WAIT,
    ST_READ,       // fetch the next stored element
    ST_DIV_GO,     // kick off the division
    ST_DIV_WAIT,
    ST_EMIT        // hand the quotient to the output register
  } state_t;

  state_t               state_r,     state_nxt;
  logic [CNT_W-1:0]     count_r,     count_nxt;
  logic [SUM_W-1:0]     sum_r,       sum_nxt;
  logic [SUM_W-1:0]     mcand_r,     mcand_nxt;
  logic [SAMPLE_W-1:0]  mplier_r,    mplier_nxt;
  logic                 final_r,     final_nxt;
  logic [ADDR_W-1:0]    rd_idx_r,    rd_idx_nxt;
  logic                 neg_r,       neg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_val_r,   out_val_nxt;
  logic                 out_end_r,   out_end_nxt;

  // element store
  logic [SAMPLE_W-1:0]  mem [DEPTH];
  logic [SAMPLE_W-1:0]  rd_data_r;
  logic                 wr_en;

  logic                 in_xfer;
  logic                 full;
  logic                 last;
  logic [SAMPLE_W-1:0]  in_mag;
  logic [SAMPLE_W-1:0]  rd_mag;
  logic [OUT_W-1:0]     q_ext;

  logic [ROOT_W-1:0]    root;
  logic [QUOT_W-1:0]    quot;
  lvn_stat_t            sqrt_stat;
  lvn_stat_t            div_stat;

  // square root of the sum of squares, held until the next vector
  lvn_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_ROOT_GO),
    .radicand (sum_r),
    .root     (root),
    .stat     (sqrt_stat)
  );

  // one quotient per stored element
  lvn_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == ST_DIV_GO),
    .mag     (rd_mag),
    .divisor (root),
    .quot    (quot),
    .stat    (div_stat)
  );

  assign in_ready = (state_r == ST_LOAD);
  assign in_xfer  = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign last     = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == count_r);

  // two's complement magnitudes; the most negative sample maps to 2^(w-1)
  assign in_mag = in_element[SAMPLE_W-1] ? (~in_element + SAMPLE_W'(1)) : in_element;
  assign rd_mag = rd_data_r[SAMPLE_W-1] ? (~rd_data_r + SAMPLE_W'(1)) : rd_data_r;
  assign q_ext  = OUT_W'(quot);
  assign wr_en  = in_xfer && !full;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    final_nxt     = final_r;
    rd_idx_nxt    = rd_idx_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_end_nxt   = out_end_r;

    // output register drains independently of the sequencer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          final_nxt = in_is_final;
          if (!full) begin
            count_nxt  = count_r + CNT_W'(1);
            mcand_nxt  = SUM_W'(in_mag);
            mplier_nxt = in_mag;
            state_nxt  = ST_SQUARE;
          end else if (in_is_final) begin
            // dropped element still closes the vector
            state_nxt = ST_ROOT_GO;
          end
        end
      end
      ST_SQUARE: begin
        if (mplier_r == '0) begin
          state_nxt = final_r ? ST_ROOT_GO : ST_LOAD;
        end else begin
          sum_nxt    = sum_r + (mplier_r[0] ? mcand_r : '0);
          mcand_nxt  = {mcand_r[SUM_W-2:0], 1'b0};
          mplier_nxt = {1'b0, mplier_r[SAMPLE_W-1:1]};
        end
      end
      ST_ROOT_GO: begin
        rd_idx_nxt = '0;
        state_nxt  = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (sqrt_stat.done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        neg_nxt   = rd_data_r[SAMPLE_W-1];
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          // zero norm means an all-zero vector: every result is zero
          if (root == '0) begin
            out_val_nxt = '0;
          end else begin
            out_val_nxt = neg_r ? (~q_ext + OUT_W'(1)) : q_ext;
          end
          out_end_nxt = last;
          if (last) begin
            count_nxt = '0;
            sum_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            rd_idx_nxt = rd_idx_r + ADDR_W'(1);
            state_nxt  = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mcand_r   <= mcand_nxt;
    mplier_r  <= mplier_nxt;
    final_r   <= final_nxt;
    rd_idx_r  <= rd_idx_nxt;
    neg_r     <= neg_nxt;
    out_val_r <= out_val_nxt;
    out_end_r <= out_end_nxt;
  end

  // store port: write on a transfer while not full, registered read for the burst
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[ADDR_W-1:0]] <= in_element;
    end
    if (state_r == ST_READ) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_unit_value    = out_val_r;
  assign out_end_of_vector = out_end_r;

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for l2_vector_normalize: vectors of q4.12 elements go
// in, every transfer is predicted locally (sum of squares, floor square root,
// q1.14 quotient truncated toward zero) and each normalised result is checked
// field by field against the oldest pending prediction
// ----------------------------------------------------------------------------
module tb_top;

  import lvn_pkg::*;

  localparam int STALL_LIMIT = 4000;  // cycles with no transfer on either side
  localparam int LONG_HOLD   = 600;   // one long receiver hold-off
  localparam int TAIL_ITEMS  = 40;    // last stretch of the run has no idling
  localparam int SETTLE      = 100;   // quiet cycles after the last result
  localparam int ITEM_GOAL   = 230;

  typedef enum int {
    MIX_FULL,
    MIX_TINY,
    MIX_EXTREME,
    MIX_ZERO
  } value_mix_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] element;
    logic                       is_final;
    logic                       drain_first;  // wait until nothing is pending
  } vec_item_t;

  typedef struct {
    logic signed [OUT_W-1:0] unit_value;
    logic                    end_of_vector;
  } unit_result_t;

  logic                       clk;
  logic                       rst_n             = 1'b0;
  logic                       in_valid          = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_element        = '0;
  logic                       in_is_final       = 1'b0;
  logic                       out_valid;
  logic                       out_ready         = 1'b0;
  logic signed [OUT_W-1:0]    out_unit_value;
  logic                       out_end_of_vector;

  // stimulus and prediction state
  vec_item_t    pending_items[$];
  unit_result_t expected_units[$];
  vec_item_t    next_item;
  unit_result_t want;

  logic signed [SAMPLE_W-1:0] vec_store [DEPTH];
  int unsigned                held_count = 0;
  longint unsigned            sq_total   = 0;

  int  items_total     = 0;
  int  items_issued    = 0;
  int  items_accepted  = 0;
  int  results_checked = 0;
  int  mismatch_count  = 0;
  int  send_gap        = 0;
  int  recv_hold       = 0;
  int  idle_cycles     = 0;
  bit  calm_tail       = 1'b0;
  bit  long_hold_done  = 1'b0;

  l2_vector_normalize dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_element        (in_element),
    .in_is_final       (in_is_final),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_unit_value    (out_unit_value),
    .out_end_of_vector (out_end_of_vector)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // floor square root, one result bit at a time from the top
  function automatic longint unsigned isqrt_floor(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // take one accepted element; a final element releases the whole vector
  task automatic absorb_element(input logic signed [SAMPLE_W-1:0] elem, input logic fin);
    longint          sx;
    longint unsigned mag;
    longint unsigned root;
    longint unsigned quo;
    longint          signed_quo;
    unit_result_t    res;
    // once the store is full further elements are dropped, sum untouched
    if (held_count < DEPTH) begin
      vec_store[held_count] = elem;
      held_count++;
      sx = elem;
      mag = (sx < 0) ? -sx : sx;
      sq_total += mag * mag;
    end
    if (fin) begin
      root = isqrt_floor(sq_total);
      for (int i = 0; i < held_count; i++) begin
        sx = vec_store[i];
        mag = (sx < 0) ? -sx : sx;
        // a zero norm stands in for the tiny floor: every output is zero
        quo = (root == 0) ? 0 : (mag << FRAC_OUT) / root;
        if (quo > (64'd1 << FRAC_OUT)) quo = 64'd1 << FRAC_OUT;
        signed_quo = (sx < 0) ? -longint'(quo) : longint'(quo);
        res.unit_value    = signed_quo[OUT_W-1:0];
        res.end_of_vector = (i == held_count - 1);
        expected_units.push_back(res);
      end
      held_count = 0;
      sq_total   = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus construction
  // --------------------------------------------------------------------------

  function automatic logic signed [SAMPLE_W-1:0] pick_element(input value_mix_t mix);
    logic signed [SAMPLE_W-1:0] v;
    case (mix)
      MIX_FULL: begin
        v = SAMPLE_W'($urandom);
      end
      MIX_TINY: begin
        v = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
      end
      MIX_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       v = 16'sh7fff;
          1:       v = -16'sh8000;
          2:       v = 16'sh0001;
          3:       v = -16'sh0001;
          4:       v = 16'sh8001;
          default: v = 16'sh7ffe;
        endcase
      end
      default: begin
        v = '0;
      end
    endcase
    return v;
  endfunction

  task automatic push_item(input logic signed [SAMPLE_W-1:0] elem, input logic fin,
                           input logic drain);
    vec_item_t it;
    it.element     = elem;
    it.is_final    = fin;
    it.drain_first = drain;
    pending_items.push_back(it);
  endtask

  // one vector of len elements, final flag on the last one
  task automatic queue_vector(input int len, input value_mix_t mix, input logic drain);
    value_mix_t m;
    for (int i = 0; i < len; i++) begin
      // a fraction of noise keeps full-range values mixed into any nonzero vector
      m = ($urandom_range(0, 7) == 0) ? MIX_FULL : mix;
      if (mix == MIX_ZERO) m = MIX_ZERO;
      push_item(pick_element(m), (i == len - 1), drain && (i == 0));
    end
  endtask

  initial begin
    value_mix_t mix;
    int         len;

    // directed: single-element extremes
    push_item(16'sh7fff, 1'b1, 1'b0);
    push_item(-16'sh8000, 1'b1, 1'b0);
    push_item(16'sh0000, 1'b1, 1'b0);   // zero vector of one element
    push_item(-16'sh0001, 1'b1, 1'b0);
    // zero vector of several elements
    push_item(16'sh0000, 1'b0, 1'b0);
    push_item(16'sh0000, 1'b0, 1'b0);
    push_item(16'sh0000, 1'b1, 1'b0);
    // mixed extremes in one vector
    push_item(16'sh7fff, 1'b0, 1'b0);
    push_item(-16'sh8000, 1'b0, 1'b0);
    push_item(16'sh0001, 1'b0, 1'b0);
    push_item(-16'sh0001, 1'b0, 1'b0);
    push_item(16'sh5555, 1'b1, 1'b0);
    // 3-4-5 triangle, sent only once the block has gone quiet
    push_item(16'sh0003, 1'b0, 1'b1);
    push_item(-16'sh0004, 1'b1, 1'b0);
    // all-equal vector, norm not a power of two
    push_item(16'sh1234, 1'b0, 1'b0);
    push_item(16'sh1234, 1'b0, 1'b0);
    push_item(16'sh1234, 1'b1, 1'b0);

    // random: a few short vectors first
    for (int k = 0; k < 4; k++) queue_vector($urandom_range(1, 6), MIX_FULL, 1'b0);
    // store filled exactly, final element is the last one stored
    queue_vector(DEPTH, value_mix_t'($urandom_range(0, 2)), 1'b0);
    // overflow: elements past the store depth are dropped, final one too
    queue_vector($urandom_range(DEPTH + 1, DEPTH + 5), MIX_FULL, 1'b1);

    // mostly short well-formed vectors with random content
    while (pending_items.size() < ITEM_GOAL) begin
      mix = value_mix_t'($urandom_range(0, 3));
      if (mix == MIX_ZERO && $urandom_range(0, 1) == 0) mix = MIX_FULL;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      queue_vector(len, mix, ($urandom_range(0, 11) == 0));
    end
    items_total = pending_items.size();

    // reset once, then let the driver and monitor run
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (items_accepted != items_total) @(posedge clk);
    while (expected_units.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (expected_units.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_units.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // driver: offers pending items, predicts on each accepted transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_element(in_element, in_is_final);
        items_accepted++;
      end
      // payload only moves once the previous transfer has gone
      if (!in_valid || in_ready) begin
        calm_tail = (pending_items.size() < TAIL_ITEMS);
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0 ||
                     (pending_items[0].drain_first && expected_units.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          next_item = pending_items.pop_front();
          in_element  <= next_item.element;
          in_is_final <= next_item.is_final;
          in_valid    <= 1'b1;
          items_issued++;
          // idle bursts, with every third window of 30 items kept busy
          if (!calm_tail && ((items_issued / 30) % 3 != 1) && $urandom_range(0, 4) == 0)
            send_gap = $urandom_range(1, 14);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each result transfer and drives back-pressure
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_units.size() == 0) begin
          $display("%0t: unexpected result, unit_value %0d end_of_vector %0b",
                   $time, out_unit_value, out_end_of_vector);
          mismatch_count++;
        end else begin
          want = expected_units.pop_front();
          if (out_unit_value !== want.unit_value) begin
            $display("%0t: unit_value mismatch, expected %0d, actual %0d",
                     $time, want.unit_value, out_unit_value);
            mismatch_count++;
          end
          if (out_end_of_vector !== want.end_of_vector) begin
            $display("%0t: end_of_vector mismatch, expected %0b, actual %0b",
                     $time, want.end_of_vector, out_end_of_vector);
            mismatch_count++;
          end
        end
        results_checked++;
      end
      // one long hold-off mid-burst so the block backs up and stalls its input
      if (!long_hold_done && out_valid && results_checked >= 40) begin
        long_hold_done = 1'b1;
        recv_hold = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (recv_hold > 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else if (!calm_tail && ((results_checked / 50) % 3 != 1) &&
                   $urandom_range(0, 5) == 0) begin
        recv_hold = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any transfer ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
